// ===== hdl/ecal_pkg.sv =====
// Shared constants, types and helpers for the epoch-to-calendar pipeline.
package ecal_pkg;

	// Seconds to days: (secs >> 7) / 675, by reciprocal multiply.
	localparam logic [16:0] SECS_PER_DAY = 17'd86400;
	localparam int          DAY_SH       = 7;
	localparam int          DAY_ODD      = 675;
	localparam int          DAY_RSH      = 35;
	localparam logic [63:0] DAY_RECIP_W  =
		((64'd1 << DAY_RSH) + 64'(DAY_ODD) - 64'd1) / 64'(DAY_ODD);
	localparam logic [25:0] DAY_RECIP    = DAY_RECIP_W[25:0];

	// Days to four-year blocks.
	localparam logic [10:0] DAYS_PER_BLOCK = 11'd1461;
	localparam int          BLK_DIV        = 1461;
	localparam int          BLK_RSH        = 27;
	localparam logic [63:0] BLK_RECIP_W    =
		((64'd1 << BLK_RSH) + 64'(BLK_DIV) - 64'd1) / 64'(BLK_DIV);
	localparam logic [16:0] BLK_RECIP      = BLK_RECIP_W[16:0];

	// Seconds of day to hours: (tod >> 4) / 225.
	localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
	localparam int          HR_SH         = 4;
	localparam int          HR_ODD        = 225;
	localparam int          HR_RSH        = 21;
	localparam logic [63:0] HR_RECIP_W    =
		((64'd1 << HR_RSH) + 64'(HR_ODD) - 64'd1) / 64'(HR_ODD);
	localparam logic [13:0] HR_RECIP      = HR_RECIP_W[13:0];

	// Seconds of hour to minutes: (soh >> 2) / 15.
	localparam logic [5:0]  SECS_PER_MIN = 6'd60;
	localparam int          MIN_SH       = 2;
	localparam int          MIN_ODD      = 15;
	localparam int          MIN_RSH      = 14;
	localparam logic [63:0] MIN_RECIP_W  =
		((64'd1 << MIN_RSH) + 64'(MIN_ODD) - 64'd1) / 64'(MIN_ODD);
	localparam logic [10:0] MIN_RECIP    = MIN_RECIP_W[10:0];

	localparam logic [11:0] BASE_YEAR       = 12'd1970;
	localparam logic [11:0] CENTURY_NOLEAP  = 12'd2100;
	localparam logic [10:0] YEAR_LEN        = 11'd365;
	localparam logic [10:0] LEAP_YEAR_LEN   = 11'd366;

	// Day of year on which each month starts, common row then leap row.
	localparam logic [8:0] MONTH_START [0:1][0:11] = '{
		'{9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
		  9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334},
		'{9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152,
		  9'd182, 9'd213, 9'd244, 9'd274, 9'd305, 9'd335}
	};

	typedef struct packed {
		logic [15:0] days;
		logic [16:0] tod;
		logic [5:0]  blk;
	} ecal_split_t;

	// Leap rule reduced to the reachable years 1970..2106: only 2100 is a
	// century that is not a leap year.
	function automatic logic leap_year(input logic [11:0] y);
		return (y[1:0] == 2'b00) && (y != CENTURY_NOLEAP);
	endfunction

endpackage

// ===== hdl/ecal_split.sv =====
// Stages 1 and 2: split seconds into days, seconds of day and four-year blocks.
module ecal_split (
	input  logic                      clk,
	input  logic                      adv,
	input  logic [31:0]               secs,
	output ecal_pkg::ecal_split_t     split
);

	logic [50:0] day_prod;
	logic [31:0] secs_s1;
	logic [15:0] days_s1;
	logic [31:0] tod_full;
	logic [32:0] blk_prod;
	ecal_pkg::ecal_split_t split_s2;

	assign day_prod = 51'(secs[31:ecal_pkg::DAY_SH]) * 51'(ecal_pkg::DAY_RECIP);

	always_ff @(posedge clk) begin
		if (adv) begin
			secs_s1 <= secs;
			days_s1 <= day_prod[ecal_pkg::DAY_RSH +: 16];
		end
	end

	assign tod_full = secs_s1 - 32'(days_s1) * 32'(ecal_pkg::SECS_PER_DAY);
	assign blk_prod = 33'(days_s1) * 33'(ecal_pkg::BLK_RECIP);

	always_ff @(posedge clk) begin
		if (adv) begin
			split_s2.days <= days_s1;
			split_s2.tod  <= tod_full[16:0];
			split_s2.blk  <= blk_prod[ecal_pkg::BLK_RSH +: 6];
		end
	end

	assign split = split_s2;

endmodule

// ===== hdl/ecal_date.sv =====
// Stages 3 to 6: year walk inside the block, then month and day lookup.
module ecal_date (
	input  logic        clk,
	input  logic        adv,
	input  logic [15:0] days,
	input  logic [5:0]  blk,
	output logic [11:0] year,
	output logic [3:0]  month,
	output logic [4:0]  day
);

	logic [15:0] rem_full;
	logic [10:0] rem_s3;
	logic [11:0] year_s3;
	logic [10:0] walk_rem;
	logic [11:0] walk_year;
	logic [8:0]  rem_s4;
	logic [11:0] year_s4;
	logic        leap_s4;
	logic [3:0]  mon_c;
	logic [8:0]  base_c;
	logic [8:0]  dom_c;
	logic [11:0] year_c;
	logic [3:0]  month_c;
	logic [4:0]  day_c;
	logic [11:0] year_s5;
	logic [3:0]  month_s5;
	logic [4:0]  day_s5;
	logic [11:0] year_s6;
	logic [3:0]  month_s6;
	logic [4:0]  day_s6;

	assign rem_full = days - 16'(blk) * 16'(ecal_pkg::DAYS_PER_BLOCK);

	always_ff @(posedge clk) begin
		if (adv) begin
			rem_s3  <= rem_full[10:0];
			year_s3 <= ecal_pkg::BASE_YEAR + {4'd0, blk, 2'b00};
		end
	end

	// Walk at most three years; a full 366 days must remain to leave a year.
	always_comb begin
		walk_rem  = rem_s3;
		walk_year = year_s3;
		for (int i = 0; i < 3; i++) begin
			if (walk_rem >= ecal_pkg::LEAP_YEAR_LEN) begin
				walk_rem  = walk_rem - (ecal_pkg::leap_year(walk_year) ?
					ecal_pkg::LEAP_YEAR_LEN : ecal_pkg::YEAR_LEN);
				walk_year = walk_year + 12'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rem_s4  <= walk_rem[8:0];
			year_s4 <= walk_year;
			leap_s4 <= ecal_pkg::leap_year(walk_year);
		end
	end

	// Month starts rise, so the last start not above the day wins.
	always_comb begin
		mon_c  = 4'd1;
		base_c = 9'd0;
		for (int i = 1; i < 12; i++) begin
			if (rem_s4 >= ecal_pkg::MONTH_START[leap_s4][i]) begin
				mon_c  = 4'(i + 1);
				base_c = ecal_pkg::MONTH_START[leap_s4][i];
			end
		end
		dom_c = rem_s4 - base_c + 9'd1;
		// Day 365 of a common year rolls over to the first of January.
		if (!leap_s4 && rem_s4 == ecal_pkg::YEAR_LEN[8:0]) begin
			year_c  = year_s4 + 12'd1;
			month_c = 4'd1;
			day_c   = 5'd1;
		end else begin
			year_c  = year_s4;
			month_c = mon_c;
			day_c   = dom_c[4:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			year_s5  <= year_c;
			month_s5 <= month_c;
			day_s5   <= day_c;
			year_s6  <= year_s5;
			month_s6 <= month_s5;
			day_s6   <= day_s5;
		end
	end

	assign year  = year_s6;
	assign month = month_s6;
	assign day   = day_s6;

endmodule

// ===== hdl/ecal_clock.sv =====
// Stages 3 to 6: split seconds of day into hour, minute and second.
module ecal_clock (
	input  logic        clk,
	input  logic        adv,
	input  logic [16:0] tod,
	output logic [4:0]  hour,
	output logic [5:0]  minute,
	output logic [5:0]  second
);

	logic [26:0] hr_prod;
	logic [16:0] tod_s3;
	logic [4:0]  hour_s3;
	logic [16:0] soh_full;
	logic [4:0]  hour_s4;
	logic [11:0] soh_s4;
	logic [20:0] min_prod;
	logic [4:0]  hour_s5;
	logic [11:0] soh_s5;
	logic [5:0]  minute_s5;
	logic [11:0] sec_full;
	logic [4:0]  hour_s6;
	logic [5:0]  minute_s6;
	logic [5:0]  second_s6;

	assign hr_prod = 27'(tod[16:ecal_pkg::HR_SH]) * 27'(ecal_pkg::HR_RECIP);

	always_ff @(posedge clk) begin
		if (adv) begin
			tod_s3  <= tod;
			hour_s3 <= hr_prod[ecal_pkg::HR_RSH +: 5];
		end
	end

	assign soh_full = tod_s3 - 17'(hour_s3) * 17'(ecal_pkg::SECS_PER_HOUR);

	always_ff @(posedge clk) begin
		if (adv) begin
			hour_s4 <= hour_s3;
			soh_s4  <= soh_full[11:0];
		end
	end

	assign min_prod = 21'(soh_s4[11:ecal_pkg::MIN_SH]) * 21'(ecal_pkg::MIN_RECIP);

	always_ff @(posedge clk) begin
		if (adv) begin
			hour_s5   <= hour_s4;
			soh_s5    <= soh_s4;
			minute_s5 <= min_prod[ecal_pkg::MIN_RSH +: 6];
		end
	end

	assign sec_full = soh_s5 - 12'(minute_s5) * 12'(ecal_pkg::SECS_PER_MIN);

	always_ff @(posedge clk) begin
		if (adv) begin
			hour_s6   <= hour_s5;
			minute_s6 <= minute_s5;
			second_s6 <= sec_full[5:0];
		end
	end

	assign hour   = hour_s6;
	assign minute = minute_s6;
	assign second = second_s6;

endmodule

// ===== hdl/epoch_seconds_to_calendar.sv =====
// Top level: six-stage epoch-seconds to calendar date and time converter.
//
//   channel  handshake            payload
//   in       in_valid, in_stall   epoch_secs, millis_in
//   out      out_valid, out_stall cal_year, cal_month, cal_day, hour_of_day,
//                                 minute_of_hour, second_of_minute, millis_out
//
// One transfer per cycle in, one per cycle out while no result is stalled;
// each result passes through the six register stages (day quotient,
// block and time of day, block remainder and hour, year walk and seconds of
// hour, month lookup and minute, output and second).
// Reset clears the stage valid bits only; the data registers are not reset.
// A stalled result freezes every stage and stalls the input in the same cycle.
module epoch_seconds_to_calendar (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] epoch_secs,
	input  logic [9:0]  millis_in,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [11:0] cal_year,
	output logic [3:0]  cal_month,
	output logic [4:0]  cal_day,
	output logic [4:0]  hour_of_day,
	output logic [5:0]  minute_of_hour,
	output logic [5:0]  second_of_minute,
	output logic [9:0]  millis_out
);

	logic adv;
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6;
	logic [9:0] millis_s1, millis_s2, millis_s3, millis_s4, millis_s5, millis_s6;
	ecal_pkg::ecal_split_t split;

	// Hold every stage while the output transfer is refused.
	assign adv      = !(valid_s6 && out_stall);
	assign in_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			millis_s1 <= millis_in;
			millis_s2 <= millis_s1;
			millis_s3 <= millis_s2;
			millis_s4 <= millis_s3;
			millis_s5 <= millis_s4;
			millis_s6 <= millis_s5;
		end
	end

	ecal_split u_split (
		.clk   (clk),
		.adv   (adv),
		.secs  (epoch_secs),
		.split (split)
	);

	ecal_date u_date (
		.clk   (clk),
		.adv   (adv),
		.days  (split.days),
		.blk   (split.blk),
		.year  (cal_year),
		.month (cal_month),
		.day   (cal_day)
	);

	ecal_clock u_clock (
		.clk    (clk),
		.adv    (adv),
		.tod    (split.tod),
		.hour   (hour_of_day),
		.minute (minute_of_hour),
		.second (second_of_minute)
	);

	assign out_valid  = valid_s6;
	assign millis_out = millis_s6;

endmodule

// ===== verif/epoch_seconds_to_calendar_tb.sv =====
// Testbench for epoch_seconds_to_calendar: directed table and random timestamps checked in order.
`timescale 1ns / 1ps

module epoch_seconds_to_calendar_tb;

	localparam int unsigned DAY_SECS    = 86400;
	localparam int unsigned HOUR_SECS   = 3600;
	localparam int unsigned MIN_SECS    = 60;
	localparam int unsigned BLOCK_DAYS  = 1461;
	localparam int unsigned EPOCH_YEAR  = 1970;
	localparam int unsigned LAST_DAY    = 49710;
	localparam int unsigned BLK_2100    = 46752;
	localparam int unsigned N_DIRECTED  = 23;
	localparam int unsigned N_RANDOM    = 1127;
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned LONG_HOLD   = 80;
	localparam int unsigned DRAIN_WAIT  = 24;

	// first day of each month, common row then leap row, with year length last
	localparam int unsigned MONTH_FIRST [2][13] = '{
		'{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334, 365},
		'{0, 31, 60, 91, 121, 152, 182, 213, 244, 274, 305, 335, 366}
	};
	localparam int unsigned EDGE_DAYS [12] = '{
		0, 58, 59, 60, 364, 365, 366, 730, 731, 1095, 1096, 1460
	};

	typedef struct packed {
		logic [11:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
		logic [9:0]  millis;
	} cal_t;

	typedef struct packed {
		logic [31:0] secs;
		logic [9:0]  ms;
		logic        known;
		cal_t        want;
	} stamp_row_t;

	localparam cal_t CAL_NONE = '0;

	localparam stamp_row_t STAMP_TAB [N_DIRECTED] = '{
		'{32'd0,          10'd0,    1'b1, '{12'd1970, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 10'd0}},
		'{32'd86399,      10'd999,  1'b1,
			'{12'd1970, 4'd1, 5'd1, 5'd23, 6'd59, 6'd59, 10'd999}},
		'{32'hFFFF_FFFF,  10'd1023, 1'b1,
			'{12'd2106, 4'd2, 5'd6, 5'd6, 6'd28, 6'd15, 10'd1023}},
		// 365 days left in 2100 after the walk: rolls to January 1
		'{32'd4133980800, 10'd512,  1'b1, '{12'd2101, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 10'd512}},
		'{32'd86400,      10'd1,    1'b0, CAL_NONE},
		'{32'd31535999,   10'd500,  1'b0, CAL_NONE},
		'{32'd31536000,   10'd2,    1'b0, CAL_NONE},
		'{32'd68169600,   10'd3,    1'b0, CAL_NONE},
		'{32'd94694399,   10'd4,    1'b0, CAL_NONE},
		'{32'd126230400,  10'd5,    1'b0, CAL_NONE},
		'{32'd951782400,  10'd6,    1'b0, CAL_NONE},
		'{32'd978307199,  10'd7,    1'b0, CAL_NONE},
		'{32'd2147483647, 10'd1000, 1'b0, CAL_NONE},
		'{32'd2147483648, 10'd1023, 1'b0, CAL_NONE},
		'{32'd4102444800, 10'd8,    1'b0, CAL_NONE},
		'{32'd4107456000, 10'd9,    1'b0, CAL_NONE},
		'{32'd4107542400, 10'd10,   1'b0, CAL_NONE},
		'{32'd4133980799, 10'd11,   1'b0, CAL_NONE},
		'{32'd4165516800, 10'd12,   1'b0, CAL_NONE},
		'{32'd4165516799, 10'd13,   1'b0, CAL_NONE},
		'{32'd4294944000, 10'd1010, 1'b0, CAL_NONE},
		'{32'hAAAA_AAAA,  10'h155,  1'b0, CAL_NONE},
		'{32'h5555_5555,  10'h2AA,  1'b0, CAL_NONE}
	};

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [31:0] epoch_secs;
	logic [9:0]  millis_in;
	logic        out_valid;
	logic        out_stall;
	logic [11:0] cal_year;
	logic [3:0]  cal_month;
	logic [4:0]  cal_day;
	logic [4:0]  hour_of_day;
	logic [5:0]  minute_of_hour;
	logic [5:0]  second_of_minute;
	logic [9:0]  millis_out;

	cal_t        expected_dates [$];
	int unsigned mismatch_cnt;
	int unsigned dates_seen;

	epoch_seconds_to_calendar dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.epoch_secs       (epoch_secs),
		.millis_in        (millis_in),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.cal_year         (cal_year),
		.cal_month        (cal_month),
		.cal_day          (cal_day),
		.hour_of_day      (hour_of_day),
		.minute_of_hour   (minute_of_hour),
		.second_of_minute (second_of_minute),
		.millis_out       (millis_out)
	);

	function automatic bit gregorian_leap(input int unsigned y);
		return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
	endfunction

	// Fixed 1461-day blocks: dates from 2 January 2102 on come out one day behind the Gregorian calendar.
	function automatic cal_t to_calendar(input logic [31:0] secs, input logic [9:0] ms);
		int unsigned days, tod, yr, rem, mon, dom;
		bit          lp;
		cal_t        r;
		days = secs / DAY_SECS;
		tod  = secs % DAY_SECS;
		yr   = EPOCH_YEAR + (days / BLOCK_DAYS) * 4;
		rem  = days % BLOCK_DAYS;
		repeat (3) begin
			if (rem >= MONTH_FIRST[1][12]) begin
				rem = rem - MONTH_FIRST[gregorian_leap(yr)][12];
				yr++;
			end
		end
		lp  = gregorian_leap(yr);
		mon = 1;
		dom = 1;
		if (rem == MONTH_FIRST[0][12] && !lp) begin
			yr++;
		end else begin
			for (int i = 1; i < 13; i++) begin
				if (MONTH_FIRST[lp][i] > rem) begin
					dom = rem - MONTH_FIRST[lp][i - 1] + 1;
					mon = i;
					break;
				end
			end
		end
		r.year   = yr[11:0];
		r.month  = mon[3:0];
		r.day    = dom[4:0];
		r.hour   = 5'(tod / HOUR_SECS);
		r.minute = 6'((tod % HOUR_SECS) / MIN_SECS);
		r.second = 6'(tod % MIN_SECS);
		r.millis = ms;
		return r;
	endfunction

	// Mix of whole-range stamps, year and month edges, and the block holding 2100.
	function automatic void pick_stamp(output logic [31:0] secs, output logic [9:0] ms);
		longint unsigned days, tod, total;
		int unsigned     kind;
		kind = $urandom_range(0, 9);
		days = 0;
		tod  = 0;
		if (kind <= 3) begin
			secs = $urandom;
		end else begin
			if (kind <= 6) begin
				days = $urandom_range(0, 34) * BLOCK_DAYS + EDGE_DAYS[$urandom_range(0, 11)];
				days = days + $urandom_range(0, 2) - 1;
			end else if (kind <= 8) begin
				days = BLK_2100 + $urandom_range(0, BLOCK_DAYS - 1);
			end else begin
				days = $urandom_range(0, LAST_DAY);
			end
			case ($urandom_range(0, 2))
				0: tod = 0;
				1: tod = DAY_SECS - 1;
				default: tod = $urandom_range(0, DAY_SECS - 1);
			endcase
			total = days * DAY_SECS + tod;
			if (total > 64'hFFFF_FFFF)
				total = 64'hFFFF_FFFF - $urandom_range(0, 2 * DAY_SECS);
			secs = total[31:0];
		end
		ms = ($urandom_range(0, 9) == 0) ? 10'($urandom_range(1000, 1023))
		                                 : 10'($urandom_range(0, 999));
	endfunction

	// Called and returning at a falling edge; holds the stamp until taken.
	task automatic send_stamp(input logic [31:0] secs, input logic [9:0] ms, input cal_t want,
	                          input bit no_gap);
		int unsigned gap;
		gap = no_gap ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid   <= 1'b1;
		epoch_secs <= secs;
		millis_in  <= ms;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		expected_dates.push_back(want);
		@(negedge clk);
	endtask

	task automatic report_bad(input string why, input cal_t want, input cal_t got);
		mismatch_cnt++;
		if (mismatch_cnt <= 10)
			$display("%0t: %s: expected %0d-%0d-%0d %0d:%0d:%0d.%0d got %0d-%0d-%0d %0d:%0d:%0d.%0d",
				$realtime, why,
				want.year, want.month, want.day, want.hour, want.minute, want.second, want.millis,
				got.year, got.month, got.day, got.hour, got.minute, got.second, got.millis);
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin : watchdog
		int unsigned cycles;
		cycles = 0;
		while (cycles <= CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Result side: random stall per transfer, calm stretches, one long hold-off.
	initial begin : receiver
		int unsigned n;
		bit          held;
		held      = 1'b0;
		out_stall = 1'b0;
		@(negedge clk);
		forever begin
			if (!held && dates_seen >= 300) begin
				held = 1'b1;
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(negedge clk);
			end else begin
				n = ((dates_seen / 150) % 3 == 2) ? 0 : $urandom_range(0, 7);
				if (n > 0) begin
					out_stall <= 1'b1;
					repeat (n) @(negedge clk);
				end
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			@(negedge clk);
		end
	end

	always @(posedge clk) begin : score
		cal_t got, want;
		if (arst_n && out_valid && !out_stall) begin
			got = '{cal_year, cal_month, cal_day, hour_of_day, minute_of_hour,
			        second_of_minute, millis_out};
			dates_seen++;
			if (expected_dates.size() == 0) begin
				report_bad("result with nothing outstanding", CAL_NONE, got);
			end else begin
				want = expected_dates.pop_front();
				if (got.year !== want.year || got.month !== want.month ||
				    got.day !== want.day || got.hour !== want.hour ||
				    got.minute !== want.minute || got.second !== want.second ||
				    got.millis !== want.millis)
					report_bad("date mismatch", want, got);
			end
		end
	end

	initial begin : stimulus
		logic [31:0] secs;
		logic [9:0]  ms;
		stamp_row_t  row;
		mismatch_cnt = 0;
		dates_seen   = 0;
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		epoch_secs   = '0;
		millis_in    = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int i = 0; i < N_DIRECTED; i++) begin
			row = STAMP_TAB[i];
			send_stamp(row.secs, row.ms, row.known ? row.want : to_calendar(row.secs, row.ms),
			           1'b0);
		end

		// every fourth run of a hundred transfers goes back to back
		for (int i = 0; i < N_RANDOM; i++) begin
			pick_stamp(secs, ms);
			send_stamp(secs, ms, to_calendar(secs, ms), (i / 100) % 4 == 3);
		end
		in_valid <= 1'b0;

		while (expected_dates.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (mismatch_cnt == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/ecal_pkg.sv
hdl/ecal_split.sv
hdl/ecal_date.sv
hdl/ecal_clock.sv
hdl/epoch_seconds_to_calendar.sv
verif/epoch_seconds_to_calendar_tb.sv
